/* rtl/core/dspl_pkg.sv */
// Package: types, constants and state codes for the depth-sorted primitive list.
package dspl_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int LINK_W = 7;
	localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_DRAINED  = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] priority_req;
		logic        kind;
		logic [31:0] handle;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] dx;
		logic [31:0] dy;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        out_kind;
		logic [31:0] out_handle;
		logic [31:0] out_ax;
		logic [31:0] out_ay;
		logic [31:0] out_bx;
		logic [31:0] out_by;
		logic [31:0] out_cx;
		logic [31:0] out_cy;
		logic [31:0] out_dx;
		logic [31:0] out_dy;
		logic        last;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE, S_WRITE, S_WALK_RD, S_WALK_CMP, S_DRAIN_RD, S_DRAIN_OUT, S_BLANK
	} state_t;

	typedef struct packed {
		logic cap_input;
		logic write_entry;
		logic head_to_slot;
		logic start_walk;
		logic read_cur;
		logic link_before;
		logic link_tail;
		logic step_walk;
		logic start_drain;
		logic emit_entry;
		logic emit_blank;
		logic clear_list;
	} cmd_t;

	typedef struct packed {
		logic is_drain;
		logic full;
		logic head_null;
		logic cur_less;
		logic next_null;
		logic drain_more;
		logic drain_last;
	} sts_t;
endpackage

/* rtl/core/dspl_ctrl.sv */
// Controller state machine for the depth-sorted primitive list.
module dspl_ctrl import dspl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_WRITE;
			S_WRITE: begin
				if (sts.is_drain) state_d = sts.drain_more ? S_DRAIN_RD : S_BLANK;
				else if (sts.full || sts.head_null) state_d = S_BLANK;
				else state_d = S_WALK_RD;
			end
			S_WALK_RD: state_d = S_WALK_CMP;
			S_WALK_CMP: state_d = (sts.cur_less || sts.next_null) ? S_BLANK : S_WALK_RD;
			S_DRAIN_RD: state_d = S_DRAIN_OUT;
			S_DRAIN_OUT: state_d = sts.drain_last ? S_IDLE : S_DRAIN_RD;
			S_BLANK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.cap_input = start;
			S_WRITE: begin
				if (sts.is_drain) cmd.start_drain = 1'b1;
				else if (!sts.full) begin
					cmd.write_entry = 1'b1;
					cmd.head_to_slot = sts.head_null;
					cmd.start_walk = !sts.head_null;
				end
			end
			S_WALK_RD: cmd.read_cur = 1'b1;
			S_WALK_CMP: begin
				if (sts.cur_less) cmd.link_before = 1'b1;
				else if (sts.next_null) cmd.link_tail = 1'b1;
				else cmd.step_walk = 1'b1;
			end
			S_DRAIN_RD: cmd.read_cur = 1'b1;
			S_DRAIN_OUT: begin
				cmd.emit_entry = 1'b1;
				cmd.clear_list = sts.drain_last;
			end
			S_BLANK: begin
				cmd.emit_blank = 1'b1;
				cmd.clear_list = sts.is_drain;
			end
			default: cmd = '0;
		endcase
	end
endmodule

/* rtl/core/dspl_dpath.sv */
// Datapath for the depth-sorted primitive list: entry memories, link walk, output word.
module dspl_dpath import dspl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_word_t out_word,
	output logic      done
);
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = 289;

	logic [LINK_W-1:0] link_mem [CAPACITY];
	logic [31:0]       prio_mem [CAPACITY];
	logic [DW-1:0]     data_mem [CAPACITY];

	in_word_t          in_q;
	logic [LINK_W-1:0] head_q, cur_q, prev_q;
	logic [CW-1:0]     count_q, n_q;
	logic [31:0]       rd_prio_q;
	logic [LINK_W-1:0] rd_link_q;
	logic [DW-1:0]     rd_data_q;
	out_word_t         out_q;
	logic              done_q;

	logic [DW-1:0]     wr_data;
	logic [LINK_W-1:0] slot;
	logic [1:0]        blank_status;

	assign slot = LINK_W'(count_q);
	always_comb begin
		wr_data = {in_q.kind, in_q.handle, in_q.ax,
			in_q.kind ? 224'd0 : {in_q.ay, in_q.bx, in_q.by, in_q.cx, in_q.cy, in_q.dx,
			in_q.dy}};
	end

	function automatic logic link_ok(input logic [LINK_W-1:0] l);
		return {25'd0, l} < 32'(CAPACITY);
	endfunction

	always_comb begin
		sts.is_drain   = in_q.operation == OP_DRAIN;
		sts.full       = count_q >= CW'(CAPACITY);
		sts.head_null  = !link_ok(head_q);
		sts.cur_less   = $signed(rd_prio_q) < $signed(in_q.priority_req);
		sts.next_null  = !link_ok(rd_link_q);
		sts.drain_more = link_ok(head_q) && (count_q != '0);
		sts.drain_last = !link_ok(rd_link_q) || (n_q + CW'(1) >= count_q);
	end

	always_comb begin
		blank_status = sts.is_drain ? ST_EMPTY : (sts.full ? ST_OVERFLOW : ST_INSERTED);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_input) in_q <= in_word;
		if (cmd.write_entry) begin
			prio_mem[slot[SW-1:0]] <= in_q.priority_req;
			data_mem[slot[SW-1:0]] <= wr_data;
			link_mem[slot[SW-1:0]] <= NULL_LINK;
		end
		if (cmd.link_before) begin
			link_mem[slot[SW-1:0]] <= cur_q;
			if (prev_q != NULL_LINK) link_mem[prev_q[SW-1:0]] <= slot;
		end
		if (cmd.link_tail) link_mem[cur_q[SW-1:0]] <= slot;
		if (cmd.read_cur) begin
			rd_prio_q <= prio_mem[cur_q[SW-1:0]];
			rd_link_q <= link_mem[cur_q[SW-1:0]];
			rd_data_q <= data_mem[cur_q[SW-1:0]];
		end
		if (cmd.emit_entry) out_q <= {ST_DRAINED, rd_data_q, sts.drain_last};
		if (cmd.emit_blank) out_q <= {blank_status, {DW{1'b0}}, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_LINK;
			count_q <= '0;
			cur_q <= NULL_LINK;
			prev_q <= NULL_LINK;
			n_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_entry || cmd.emit_blank;
			if (cmd.emit_blank && !sts.is_drain && !sts.full) count_q <= count_q + CW'(1);
			if (cmd.head_to_slot) head_q <= slot;
			if (cmd.start_walk || cmd.start_drain) begin
				cur_q <= head_q;
				prev_q <= NULL_LINK;
				n_q <= '0;
			end
			if (cmd.link_before && prev_q == NULL_LINK) head_q <= slot;
			if (cmd.step_walk) begin
				prev_q <= cur_q;
				cur_q <= rd_link_q;
			end
			if (cmd.emit_entry) begin
				cur_q <= rd_link_q;
				n_q <= n_q + CW'(1);
			end
			if (cmd.clear_list) begin
				head_q <= NULL_LINK;
				count_q <= '0;
			end
		end
	end

	assign out_word = out_q;
	assign done = done_q;
endmodule

/* rtl/core/depth_sorted_primitive_list_unit.sv */
// Top level of the depth-sorted primitive list.
// channel | signals                  | accepted when
// input   | start, busy, in_word     | start && !busy at clk
// result  | done, out_word           | done high, one cycle per word
// Insert: unless full, the entry is written and the list walked, one entry read and compare per step.
// Drain: one memory read per entry emitted; an empty list gives a single blank word.
// Reset clears head, count, walk pointers and done; the stores need no clearing.
// Results cannot be stalled; busy stays high until the last word is shown.
module depth_sorted_primitive_list_unit import dspl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  in_word,
	output logic      busy,
	output logic      done,
	output out_word_t out_word
);
	cmd_t cmd;
	sts_t sts;

	dspl_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .cmd, .busy);
	dspl_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk, .arst_n, .in_word, .cmd, .sts, .out_word, .done);
endmodule

/* rtl/core/dspl_checker.sv */
// Port checker for the depth-sorted primitive list, bound to the top level.
module dspl_port_checker import dspl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_word_t out_word
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_word.last |-> busy) else $error("busy fell mid drain");
	a_blank_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.status != ST_DRAINED |-> out_word.last)
		else $error("blank word not last");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.last |-> !busy) else $error("busy after last word");
endmodule

bind depth_sorted_primitive_list_unit dspl_port_checker u_checker (
	.clk, .arst_n, .start, .busy, .done, .out_word);

/* verif/dspl_checker.sv */
// Checker: watches the input and result channels of the primitive list and compares.
module dspl_checker import dspl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_word_t  in_word,
	input  logic      done,
	input  out_word_t out_word,
	output int        fail_count,
	output int        pending
);
	logic [31:0] prio_q [$];
	in_word_t    entry_q [$];
	out_word_t   expected_words [$];

	function automatic out_word_t blank_word(logic [1:0] st);
		out_word_t w;
		w = '0;
		w.status = st;
		w.last = 1'b1;
		return w;
	endfunction

	task automatic predict_word(input in_word_t w);
		int pos;
		out_word_t o;
		in_word_t e;
		if (w.operation == OP_INSERT) begin
			if (entry_q.size() >= CAPACITY) begin
				expected_words.push_back(blank_word(ST_OVERFLOW));
			end else begin
				e = w;
				if (w.kind) begin
					e.ay = '0; e.bx = '0; e.by = '0; e.cx = '0;
					e.cy = '0; e.dx = '0; e.dy = '0;
				end
				pos = entry_q.size();
				for (int i = 0; i < entry_q.size(); i++) begin
					if ($signed(prio_q[i]) < $signed(w.priority_req)) begin
						pos = i;
						break;
					end
				end
				entry_q.insert(pos, e);
				prio_q.insert(pos, w.priority_req);
				expected_words.push_back(blank_word(ST_INSERTED));
			end
		end else begin
			if (entry_q.size() == 0) begin
				expected_words.push_back(blank_word(ST_EMPTY));
			end
			for (int i = 0; i < entry_q.size(); i++) begin
				e = entry_q[i];
				o.status = ST_DRAINED;
				o.out_kind = e.kind;
				o.out_handle = e.handle;
				o.out_ax = e.ax; o.out_ay = e.ay;
				o.out_bx = e.bx; o.out_by = e.by;
				o.out_cx = e.cx; o.out_cy = e.cy;
				o.out_dx = e.dx; o.out_dy = e.dy;
				o.last = (i == entry_q.size() - 1);
				expected_words.push_back(o);
			end
			entry_q.delete();
			prio_q.delete();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: %h", out_word);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (out_word !== exp_w) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", exp_w, out_word);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				predict_word(in_word);
			pending <= expected_words.size();
		end
	end
endmodule

/* verif/tb_depth_sorted_primitive_list_unit.sv */
// Testbench top: drives insert and drain words into the primitive list and reports.
module tb_depth_sorted_primitive_list_unit;
	import dspl_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_word_t  in_word = '0;
	logic      busy;
	logic      done;
	out_word_t out_word;
	int        fail_count;
	int        pending;

	always #5 clk = ~clk;

	depth_sorted_primitive_list_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word),
		.busy(busy), .done(done), .out_word(out_word)
	);

	dspl_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .out_word(out_word), .fail_count(fail_count), .pending(pending)
	);

	function automatic in_word_t rand_word(logic op, logic [31:0] prio);
		in_word_t w;
		w.operation = op;
		w.priority_req = prio;
		w.kind = 1'($urandom_range(0, 1));
		w.handle = $urandom;
		w.ax = $urandom; w.ay = $urandom; w.bx = $urandom; w.by = $urandom;
		w.cx = $urandom; w.cy = $urandom; w.dx = $urandom; w.dy = $urandom;
		return w;
	endfunction

	function automatic logic [31:0] rand_prio();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3) << 16;
			1: return 32'h8000_0000 + $urandom_range(0, 1);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input in_word_t w);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(posedge clk);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		start <= 1'b1;
		in_word <= w;
		@(posedge clk);
		start <= 1'b0;
	endtask

	initial begin
		in_word_t w;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(rand_word(OP_DRAIN, '0));
		w = '1; w.operation = OP_INSERT; w.kind = 1'b0;
		send(w);
		w.kind = 1'b1;
		send(w);
		send('0);
		send(rand_word(OP_INSERT, 32'h8000_0000));
		send(rand_word(OP_INSERT, 32'h7FFF_FFFF));
		send(rand_word(OP_INSERT, 32'h0001_0000));
		send(rand_word(OP_INSERT, 32'h0001_0000));
		send(rand_word(OP_INSERT, 32'hFFFF_0000));
		send(rand_word(OP_DRAIN, '0));
		send(rand_word(OP_DRAIN, '0));
		for (int i = 0; i < 66; i++)
			send(rand_word(OP_INSERT, $urandom_range(0, 3) << 16));
		send(rand_word(OP_DRAIN, '0));
		n = 0;
		while (n < 40) begin
			for (int i = $urandom_range(0, 12); i > 0; i--) begin
				send(rand_word(OP_INSERT, rand_prio()));
				n++;
			end
			send(rand_word(OP_DRAIN, '0));
			n++;
		end
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end
endmodule

/* files.f */
rtl/core/dspl_pkg.sv
rtl/core/dspl_ctrl.sv
rtl/core/dspl_dpath.sv
rtl/core/depth_sorted_primitive_list_unit.sv
rtl/core/dspl_checker.sv
verif/dspl_checker.sv
verif/tb_depth_sorted_primitive_list_unit.sv
